// ===== hdl/bmp565_pkg.sv =====
// Shared types, codes and helper functions for the bitmap byte to RGB565 converter.
`default_nettype none

package bmp565_pkg;

    // Default palette depth.
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Input opcodes.
    localparam logic [1:0] OP_PIXEL_BYTE = 2'd0;
    localparam logic [1:0] OP_PAL_WRITE  = 2'd1;
    localparam logic [1:0] OP_FILL       = 2'd2;

    // Source pixel modes; any other code is handled as 32-bit BGRA.
    localparam logic [1:0] MODE_PAL8  = 2'd0;
    localparam logic [1:0] MODE_BGR24 = 2'd1;

    // Configuration register indexes.
    localparam logic REG_PIXEL_MODE  = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    // Color emitted for a pixel that could not be read.
    localparam logic [15:0] FILL_565 = 16'h001F;

    // Command kinds carried through the queue.
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_PAL_WRITE  = 2'd0;
    localparam cmd_kind_t CMD_PAL_LOOKUP = 2'd1;
    localparam cmd_kind_t CMD_DIRECT     = 2'd2;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;
        logic [7:0]  addr;
        logic [23:0] data;
    } cmd_t;

    // Truncating conversion of 8-bit channels to RGB565.
    function automatic logic [15:0] to_565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        to_565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Byte offset of a pixel count for the given mode (1, 3 or 4 bytes per pixel).
    function automatic logic [17:0] times_bpp(input logic [16:0] count, input logic [1:0] mode);
        logic [17:0] c;
        c = {1'b0, count};
        case (mode)
            MODE_PAL8:  times_bpp = c;
            MODE_BGR24: times_bpp = c + {c[16:0], 1'b0};
            default:    times_bpp = {c[15:0], 2'b00};
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bmp565_if.sv =====
// Handshake interfaces for the pixel input, pixel output and configuration channels.
`default_nettype none

interface bmp565_pix_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [7:0]  palette_slot;
    logic [23:0] palette_rgb;

    modport source (output valid, output opcode, output data_byte, output palette_slot,
                    output palette_rgb, input ready);
    modport sink   (input valid, input opcode, input data_byte, input palette_slot,
                    input palette_rgb, output ready);
endinterface

interface bmp565_pix_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_565;
    logic        last_in_row;

    modport source (output valid, output pixel_565, output last_in_row, input ready);
    modport sink   (input valid, input pixel_565, input last_in_row, output ready);
endinterface

interface bmp565_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmp565_front.sv =====
// Front part: configuration registers, row tracking and request classification.
`default_nettype none

module bmp565_front
    import bmp565_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bmp565_pix_in_if.sink     pixel_in,
    bmp565_cfg_if.sink        cfg,
    input  wire logic         q_full,
    output logic              push,
    output cmd_t              cmd
);

    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    logic [1:0]  pixel_mode_reg;
    logic [15:0] image_width_reg;
    logic [17:0] byte_pos_reg, byte_pos_next;
    logic [15:0] column_reg, column_next;
    logic [7:0]  held_blue_reg, held_blue_next;
    logic [7:0]  held_green_reg, held_green_next;

    logic        accept;
    logic [17:0] width18;
    logic [17:0] row_len;
    logic [2:0]  bpp;
    logic [17:0] base;
    logic [17:0] offset;
    logic        in_pixel;
    logic [1:0]  sub;
    logic        last_px;
    logic [15:0] col_fill;
    logic        fill_last;
    logic [16:0] col_fill_inc;
    logic        fill_wraps;
    logic [17:0] bp_inc;
    logic        row_end;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg  <= MODE_BGR24;
            image_width_reg <= 16'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIXEL_MODE:  pixel_mode_reg  <= cfg.data[1:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Input side stalls only when the command queue is full.
    assign pixel_in.ready = !q_full;
    assign accept = pixel_in.valid && !q_full;

    // Row length in bytes, rounded up to a 4-byte boundary.
    assign width18 = {2'b00, image_width_reg};
    always_comb
    begin
        case (pixel_mode_reg)
            MODE_PAL8:
            begin
                row_len = (width18 + 18'd3) & ~18'd3;
                bpp     = 3'd1;
            end
            MODE_BGR24:
            begin
                row_len = (width18 + {width18[16:0], 1'b0} + 18'd3) & ~18'd3;
                bpp     = 3'd3;
            end
            default:
            begin
                row_len = {image_width_reg, 2'b00};
                bpp     = 3'd4;
            end
        endcase
    end

    // Position of the current byte relative to the pixel being built.
    assign base     = times_bpp({1'b0, column_reg}, pixel_mode_reg);
    assign offset   = byte_pos_reg - base;
    assign in_pixel = (byte_pos_reg >= base) && (offset < {15'd0, bpp});
    assign sub      = offset[1:0];
    assign last_px  = (column_reg == image_width_reg - 16'd1);

    // A fill that lands in padding starts the next row first.
    assign col_fill     = (column_reg >= image_width_reg) ? 16'd0 : column_reg;
    assign fill_last    = (col_fill == image_width_reg - 16'd1);
    assign col_fill_inc = {1'b0, col_fill} + 17'd1;
    assign fill_wraps   = (col_fill_inc >= {1'b0, image_width_reg});

    assign bp_inc  = byte_pos_reg + 18'd1;
    assign row_end = (bp_inc >= row_len) || (bp_inc == 18'd0);

    // Classify the request and advance the row state.
    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        column_next     = column_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        push            = 1'b0;
        cmd             = '0;
        if (accept)
        begin
            case (pixel_in.opcode)
                OP_PAL_WRITE:
                begin
                    if ({1'b0, pixel_in.palette_slot} < PAL_LIMIT)
                    begin
                        push      = 1'b1;
                        cmd.kind  = CMD_PAL_WRITE;
                        cmd.addr  = pixel_in.palette_slot;
                        cmd.data  = pixel_in.palette_rgb;
                    end
                end
                OP_PIXEL_BYTE:
                begin
                    if (image_width_reg != 16'd0)
                    begin
                        if ((column_reg < image_width_reg) && in_pixel)
                        begin
                            if (pixel_mode_reg == MODE_PAL8)
                            begin
                                push     = 1'b1;
                                cmd.last = last_px;
                                cmd.addr = pixel_in.data_byte;
                                if ({1'b0, pixel_in.data_byte} < PAL_LIMIT)
                                    cmd.kind = CMD_PAL_LOOKUP;
                                else
                                    cmd.kind = CMD_DIRECT;
                            end
                            else
                            begin
                                case (sub)
                                    2'd0: held_blue_next  = pixel_in.data_byte;
                                    2'd1: held_green_next = pixel_in.data_byte;
                                    2'd2:
                                    begin
                                        push      = 1'b1;
                                        cmd.kind  = CMD_DIRECT;
                                        cmd.last  = last_px;
                                        cmd.data  = {8'd0, to_565(pixel_in.data_byte,
                                                                  held_green_reg,
                                                                  held_blue_reg)};
                                    end
                                    default: ;
                                endcase
                            end
                            if (sub == 2'(bpp - 3'd1))
                                column_next = column_reg + 16'd1;
                        end
                        byte_pos_next = bp_inc;
                        if (row_end)
                        begin
                            byte_pos_next = 18'd0;
                            column_next   = 16'd0;
                        end
                    end
                end
                OP_FILL:
                begin
                    if (image_width_reg != 16'd0)
                    begin
                        push     = 1'b1;
                        cmd.kind = CMD_DIRECT;
                        cmd.last = fill_last;
                        cmd.data = {8'd0, FILL_565};
                        if (fill_wraps)
                        begin
                            byte_pos_next = 18'd0;
                            column_next   = 16'd0;
                        end
                        else
                        begin
                            column_next   = col_fill_inc[15:0];
                            byte_pos_next = times_bpp(col_fill_inc, pixel_mode_reg);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= 18'd0;
            column_reg     <= 16'd0;
            held_blue_reg  <= 8'd0;
            held_green_reg <= 8'd0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            column_reg     <= column_next;
            held_blue_reg  <= held_blue_next;
            held_green_reg <= held_green_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bmp565_queue.sv =====
// Short command queue that decouples the front part from the back part.
`default_nettype none

module bmp565_queue
    import bmp565_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output cmd_t       head_cmd
);

    cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bmp565_back.sv =====
// Back part: palette memory, lookup stage and output register.
`default_nettype none

module bmp565_back
    import bmp565_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  wire cmd_t         head_cmd,
    output logic              pop,
    bmp565_pix_out_if.source  pixel_out
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [23:0]       palette_mem_reg [PALETTE_ENTRIES];
    logic [PAL_AW-1:0] pal_addr;

    logic              s1_valid_reg;
    logic              s1_lookup_reg;
    logic              s1_last_reg;
    logic [15:0]       s1_value_reg;
    logic [23:0]       rd_data_reg;

    logic              out_valid_reg;
    logic [15:0]       out_pixel_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              s1_advance;

    assign out_free   = !out_valid_reg || pixel_out.ready;
    assign s1_advance = !s1_valid_reg || out_free;
    assign pop        = head_valid && s1_advance;
    assign pal_addr   = head_cmd.addr[PAL_AW-1:0];

    // Palette memory: at most one write or one read per popped command.
    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.kind == CMD_PAL_WRITE)
            palette_mem_reg[pal_addr] <= head_cmd.data;
        if (pop && head_cmd.kind == CMD_PAL_LOOKUP)
            rd_data_reg <= palette_mem_reg[pal_addr];
    end

    // Lookup stage holds the request while the palette read completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_advance)
            s1_valid_reg <= pop && (head_cmd.kind != CMD_PAL_WRITE);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_lookup_reg <= (head_cmd.kind == CMD_PAL_LOOKUP);
            s1_last_reg   <= head_cmd.last;
            s1_value_reg  <= head_cmd.data[15:0];
        end
    end

    // Output register; refills in the same cycle its request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_last_reg  <= s1_last_reg;
            out_pixel_reg <= s1_lookup_reg
                           ? to_565(rd_data_reg[23:16], rd_data_reg[15:8], rd_data_reg[7:0])
                           : s1_value_reg;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_565   = out_pixel_reg;
    assign pixel_out.last_in_row = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/bmp_pixel_bytes_to_rgb565.sv =====
// Top level of the bitmap pixel byte to RGB565 converter.
//
//   Channel    Direction  Request contents
//   pixel_in   sink       opcode, data_byte, palette_slot, palette_rgb
//   pixel_out  source     pixel_565, last_in_row
//   cfg        sink       index (0 pixel_mode, 1 image_width), data
//
// One request is accepted per clock while the command queue is not full; its result
// passes the command queue entry, palette read stage and output register in turn.
// The front stalls only when the four-entry command queue is full; the back
// drains it one command per cycle while the output is taken.
// Reset clears the row state and sets 24-bit mode with a width of one pixel.
// Palette contents are not cleared by reset.
`default_nettype none

module bmp_pixel_bytes_to_rgb565
    import bmp565_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bmp565_pix_in_if.sink     pixel_in,
    bmp565_pix_out_if.source  pixel_out,
    bmp565_cfg_if.sink        cfg
);

    logic  q_full;
    logic  push;
    cmd_t  push_cmd;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    bmp565_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    bmp565_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bmp565_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .pixel_out  (pixel_out)
    );

endmodule

`default_nettype wire

// ===== verif/tb_bmp_pixel_bytes_to_rgb565.sv =====
// Self-checking testbench for the bitmap pixel byte to RGB565 converter.
`timescale 1ns / 1ps

module tb_bmp_pixel_bytes_to_rgb565;
    import bmp565_pkg::*;

    // Codes that the package does not name.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_BGRA32 = 2'd2;
    localparam logic [1:0] MODE_ALT32  = 2'd3;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [7:0]  palette_slot;
        logic [23:0] palette_rgb;
    } pix_req_t;

    typedef struct packed {
        logic [15:0] pixel_565;
        logic        last_in_row;
    } pix_res_t;

    logic clk;
    logic rst_n;

    bmp565_pix_in_if  pix_in ();
    bmp565_pix_out_if pix_out ();
    bmp565_cfg_if     cfg_bus ();

    bmp_pixel_bytes_to_rgb565 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_in),
        .pixel_out (pix_out),
        .cfg       (cfg_bus)
    );

    // Shadow copy of the converter state and its settings.
    logic [1:0]  cur_mode;
    logic [15:0] cur_width;
    logic [17:0] row_byte_pos;
    logic [15:0] row_col_cnt;
    logic [7:0]  held_b;
    logic [7:0]  held_g;
    logic [23:0] palette_mem [256];

    // Requests waiting to be driven and pixels still owed by the block.
    pix_req_t stream_q [$];
    pix_res_t due_pixels [$];
    pix_req_t drv_req;

    // Palette slots already loaded, so lookups never hit an empty entry.
    logic [7:0] pal_slots [$];
    bit         slot_seen [256];

    int queued_reqs;
    int taken_reqs;
    int fail_cnt;
    int cycle_cnt;
    int in_gap_pct;
    int out_stall_pct;
    int in_gap_left;
    int out_stall_left;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [15:0] pack_rgb565(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Idle length: mostly short, now and then a long pause.
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advances the shadow state by one request; returns 1 when a pixel comes out.
    function automatic bit step_converter(input pix_req_t rq, output pix_res_t res);
        int unsigned bpp;
        int unsigned base;
        int unsigned sub;
        int unsigned row_len;
        logic [23:0] color;
        bit          hit;

        hit = 1'b0;
        res = '0;
        bpp = (cur_mode == MODE_PAL8) ? 1 : (cur_mode == MODE_BGR24) ? 3 : 4;

        if (rq.opcode == OP_PAL_WRITE) begin
            palette_mem[rq.palette_slot] = rq.palette_rgb;
            return 1'b0;
        end
        if (rq.opcode == OP_UNUSED || cur_width == 16'd0)
            return 1'b0;

        // A fill replaces the current pixel; in padding it opens the next row.
        if (rq.opcode == OP_FILL) begin
            if (row_col_cnt >= cur_width) begin
                row_byte_pos = '0;
                row_col_cnt  = '0;
            end
            res.pixel_565   = FILL_565;
            res.last_in_row = (row_col_cnt == cur_width - 1);
            row_col_cnt++;
            if (row_col_cnt >= cur_width) begin
                row_byte_pos = '0;
                row_col_cnt  = '0;
            end else begin
                row_byte_pos = 18'(row_col_cnt * bpp);
            end
            return 1'b1;
        end

        // Pixel data byte: placed by its offset within the current pixel.
        if (row_col_cnt < cur_width) begin
            base = row_col_cnt * bpp;
            if (row_byte_pos >= base && row_byte_pos - base < bpp) begin
                sub = row_byte_pos - base;
                res.last_in_row = (row_col_cnt == cur_width - 1);
                if (bpp == 1) begin
                    color         = palette_mem[rq.data_byte];
                    res.pixel_565 = pack_rgb565(color[23:16], color[15:8], color[7:0]);
                    hit           = 1'b1;
                end else if (sub == 0) begin
                    held_b = rq.data_byte;
                end else if (sub == 1) begin
                    held_g = rq.data_byte;
                end else if (sub == 2) begin
                    res.pixel_565 = pack_rgb565(rq.data_byte, held_g, held_b);
                    hit           = 1'b1;
                end
                if (sub == bpp - 1)
                    row_col_cnt++;
            end
        end
        row_byte_pos = row_byte_pos + 18'd1;
        row_len = ((cur_width * bpp * 8 + 31) / 32) * 4;
        if (row_byte_pos >= row_len || row_byte_pos == 18'd0) begin
            row_byte_pos = '0;
            row_col_cnt  = '0;
        end
        return hit;
    endfunction

    // Request driver: holds each request until it is taken, then maybe pauses.
    always @(posedge clk) begin : req_driver
        pix_res_t res;
        if (rst_n) begin
            if (pix_in.valid && pix_in.ready) begin
                if (step_converter(drv_req, res))
                    due_pixels.push_back(res);
                taken_reqs++;
                if ($urandom_range(0, 99) < in_gap_pct)
                    in_gap_left = pick_pause();
            end
            if (pix_in.valid && !pix_in.ready) begin
                // Hold the current request.
            end else if (in_gap_left > 0) begin
                in_gap_left--;
                pix_in.valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
                drv_req = stream_q.pop_front();
                pix_in.opcode       <= drv_req.opcode;
                pix_in.data_byte    <= drv_req.data_byte;
                pix_in.palette_slot <= drv_req.palette_slot;
                pix_in.palette_rgb  <= drv_req.palette_rgb;
                pix_in.valid        <= 1'b1;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each pixel against the oldest one owed, and stalls at random.
    always @(posedge clk) begin : pixel_monitor
        pix_res_t want;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            if (due_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_565 16'h%04h, last_in_row %0b",
                       pix_out.pixel_565, pix_out.last_in_row);
                fail_cnt++;
            end else begin
                want = due_pixels.pop_front();
                if (pix_out.pixel_565 !== want.pixel_565) begin
                    $error("pixel_565 mismatch: expected 16'h%04h, got 16'h%04h",
                           want.pixel_565, pix_out.pixel_565);
                    fail_cnt++;
                end
                if (pix_out.last_in_row !== want.last_in_row) begin
                    $error("last_in_row mismatch: expected %0b, got %0b",
                           want.last_in_row, pix_out.last_in_row);
                    fail_cnt++;
                end
            end
        end
        if (out_stall_left > 0) begin
            out_stall_left--;
            pix_out.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < out_stall_pct) begin
            out_stall_left = pick_pause() - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] op, input logic [7:0] b, input logic [7:0] slot,
                           input logic [23:0] rgb);
        stream_q.push_back('{op, b, slot, rgb});
        queued_reqs++;
        if (op == OP_PAL_WRITE && !slot_seen[slot]) begin
            slot_seen[slot] = 1'b1;
            pal_slots.push_back(slot);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_req(OP_PIXEL_BYTE, b, 8'($urandom), 24'($urandom));
    endtask

    // Register write; the caller issues it only while the block is idle, the block does not enforce it.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_PIXEL_MODE)
            cur_mode = val[1:0];
        else
            cur_width = val;
    endtask

    // Waits until every request is taken and every owed pixel has come out.
    task automatic wait_drained();
        do @(posedge clk); while (taken_reqs != queued_reqs || due_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random mix: mostly data bytes, with fills, palette loads and unused opcodes.
    task automatic add_random(input int n);
        int          made;
        int          r;
        logic [7:0]  b;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                if (cur_mode == MODE_PAL8)
                    b = pal_slots[$urandom_range(0, pal_slots.size() - 1)];
                else
                    b = 8'($urandom);
                add_byte(b);
                made++;
            end else if (r < 88) begin
                add_req(OP_FILL, 8'($urandom), 8'($urandom), 24'($urandom));
                made++;
            end else if (r < 96) begin
                add_req(OP_PAL_WRITE, 8'($urandom), 8'($urandom), 24'($urandom));
                made++;
            end else begin
                add_req(OP_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
            end
        end
    endtask

    initial begin : run_seq
        logic [1:0]  ph_mode;
        logic [15:0] ph_width;
        int          ph_items;

        cur_mode       = MODE_BGR24;
        cur_width      = 16'd1;
        row_byte_pos   = '0;
        row_col_cnt    = '0;
        held_b         = '0;
        held_g         = '0;
        queued_reqs    = 0;
        taken_reqs     = 0;
        fail_cnt       = 0;
        cycle_cnt      = 0;
        in_gap_pct     = 20;
        out_stall_pct  = 20;
        in_gap_left    = 0;
        out_stall_left = 0;
        drv_req        = '0;

        pix_in.valid        = 1'b0;
        pix_in.opcode       = OP_PIXEL_BYTE;
        pix_in.data_byte    = '0;
        pix_in.palette_slot = '0;
        pix_in.palette_rgb  = '0;
        pix_out.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_PIXEL_MODE;
        cfg_bus.data        = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one 24-bit pixel per row plus one padding byte.
        add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h00);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'hFF);
        add_req(OP_FILL, 8'h00, 8'h00, 24'h000000);
        // Fill after a partial pixel drops the byte already taken.
        add_byte(8'h12);
        add_req(OP_FILL, 8'hFF, 8'hFF, 24'hFFFFFF);
        add_req(OP_UNUSED, 8'hA5, 8'h3C, 24'h5A5A5A);
        add_req(OP_PAL_WRITE, 8'h00, 8'h00, 24'h000000);
        add_req(OP_PAL_WRITE, 8'h00, 8'hFF, 24'hFFFFFF);
        add_req(OP_PAL_WRITE, 8'h00, 8'h5A, 24'hA5C3E1);
        wait_drained();

        // Palette mode, three pixels per row; a fill lands in the padding.
        write_reg(REG_PIXEL_MODE, {14'd0, MODE_PAL8});
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'h5A);
        add_req(OP_FILL, 8'h00, 8'h00, 24'h000000);
        add_byte(8'h5A); add_byte(8'hFF); add_byte(8'h00);
        wait_drained();

        // 32-bit mode: the alpha byte only closes the pixel.
        write_reg(REG_PIXEL_MODE, {14'd0, MODE_BGRA32});
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80);
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00); add_byte(8'h7F);
        wait_drained();

        // Random phases over a spread of settings, extremes included.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin ph_mode = MODE_BGR24;  ph_width = 16'd5;     ph_items = 150;
                         in_gap_pct = 30; out_stall_pct = 30; end
                1: begin ph_mode = MODE_PAL8;   ph_width = 16'd7;     ph_items = 150;
                         in_gap_pct = 0;  out_stall_pct = 0;  end
                2: begin ph_mode = MODE_BGRA32; ph_width = 16'd3;     ph_items = 150;
                         in_gap_pct = 25; out_stall_pct = 40; end
                3: begin ph_mode = MODE_ALT32;  ph_width = 16'd2;     ph_items = 120;
                         in_gap_pct = 30; out_stall_pct = 20; end
                4: begin ph_mode = MODE_BGR24;  ph_width = 16'd0;     ph_items = 60;
                         in_gap_pct = 20; out_stall_pct = 20; end
                5: begin ph_mode = MODE_PAL8;   ph_width = 16'd1;     ph_items = 120;
                         in_gap_pct = 30; out_stall_pct = 30; end
                6: begin ph_mode = MODE_BGRA32; ph_width = 16'hFFFF;  ph_items = 100;
                         in_gap_pct = 20; out_stall_pct = 20; end
                7: begin ph_mode = MODE_BGR24;  ph_width = 16'd1;     ph_items = 100;
                         in_gap_pct = 40; out_stall_pct = 40; end
                8: begin ph_mode = MODE_PAL8;   ph_width = 16'hFFFF;  ph_items = 80;
                         in_gap_pct = 0;  out_stall_pct = 0;  end
                default: begin
                    ph_mode = MODE_BGR24; ph_width = 16'($urandom_range(1, 9));
                    ph_items = 150; in_gap_pct = 30; out_stall_pct = 30;
                end
            endcase
            write_reg(REG_PIXEL_MODE, {14'd0, ph_mode});
            write_reg(REG_IMAGE_WIDTH, ph_width);
            // Palette phases load a batch of random entries first.
            if (ph_mode == MODE_PAL8) begin
                repeat (48) add_req(OP_PAL_WRITE, 8'($urandom), 8'($urandom), 24'($urandom));
            end
            add_random(ph_items);
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bmp565_pkg.sv
hdl/bmp565_if.sv
hdl/bmp565_front.sv
hdl/bmp565_queue.sv
hdl/bmp565_back.sv
hdl/bmp_pixel_bytes_to_rgb565.sv
verif/tb_bmp_pixel_bytes_to_rgb565.sv
